### hw/rtl/lrb_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package lrb_pkg;

    // Default coordinate width within a tile (legal range 2 to 6).
    localparam int COORD_BITS_DEF = 6;

    // Width of a packed RGB888 color.
    localparam int COLOR_W = 24;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } t_state;

    // Control from the sequencer to the stepping unit.
    typedef struct packed {
        logic load;
        logic run;
    } t_step_ctl;

endpackage

`default_nettype wire

### hw/rtl/lrb_if.sv
// Valid/ready channel interfaces of the line rasterizer: commands, pixels, color.
// Depends on lrb_pkg for default widths.
`default_nettype none

// Line command channel: two endpoints per request.
interface lrb_cmd_if #(
    parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// Pixel channel: one pixel per request.
interface lrb_pix_if #(
    parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic [COORD_BITS-1:0]       pixel_x;
    logic [COORD_BITS-1:0]       pixel_y;
    logic [lrb_pkg::COLOR_W-1:0] pixel_color;
    logic                        last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// Color register write channel.
interface lrb_cfg_if ();
    logic                        valid;
    logic                        ready;
    logic [lrb_pkg::COLOR_W-1:0] line_color;

    modport source (output valid, line_color, input ready);
    modport sink   (input valid, line_color, output ready);
endinterface

`default_nettype wire

### hw/rtl/lrb_setup.sv
// Line setup: picks the major axis, orders the endpoints and registers the extents.
// Depends on lrb_pkg.
`default_nettype none

module lrb_setup #(
    parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_load,
    input  wire [COORD_BITS-1:0] i_start_x,
    input  wire [COORD_BITS-1:0] i_start_y,
    input  wire [COORD_BITS-1:0] i_end_x,
    input  wire [COORD_BITS-1:0] i_end_y,
    output logic                  o_steep,
    output logic [COORD_BITS-1:0] o_maj0,
    output logic [COORD_BITS-1:0] o_min0,
    output logic [COORD_BITS-1:0] o_maj1,
    output logic [COORD_BITS-1:0] o_dx,
    output logic [COORD_BITS-1:0] o_dy,
    output logic                  o_step_neg
);
    import lrb_pkg::*;

    logic [COORD_BITS-1:0] adx, ady;
    logic                  steep;
    logic [COORD_BITS-1:0] a0, b0, a1, b1;
    logic [COORD_BITS-1:0] maj0, min0, maj1, min1;

    logic                  r_steep,    n_steep;
    logic [COORD_BITS-1:0] r_maj0,     n_maj0;
    logic [COORD_BITS-1:0] r_min0,     n_min0;
    logic [COORD_BITS-1:0] r_maj1,     n_maj1;
    logic [COORD_BITS-1:0] r_dx,       n_dx;
    logic [COORD_BITS-1:0] r_dy,       n_dy;
    logic                  r_step_neg, n_step_neg;

    // Absolute extents decide which axis is major; ties keep x as major.
    always_comb begin
        adx   = (i_start_x > i_end_x) ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady   = (i_start_y > i_end_y) ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        steep = (adx < ady);
        a0    = steep ? i_start_y : i_start_x;
        b0    = steep ? i_start_x : i_start_y;
        a1    = steep ? i_end_y   : i_end_x;
        b1    = steep ? i_end_x   : i_end_y;
    end

    // Order the endpoints so that the major coordinate increases.
    always_comb begin
        if (a0 > a1) begin
            maj0 = a1;
            min0 = b1;
            maj1 = a0;
            min1 = b0;
        end else begin
            maj0 = a0;
            min0 = b0;
            maj1 = a1;
            min1 = b1;
        end
        n_steep    = steep;
        n_maj0     = maj0;
        n_min0     = min0;
        n_maj1     = maj1;
        n_dx       = maj1 - maj0;
        n_dy       = (min1 > min0) ? (min1 - min0) : (min0 - min1);
        n_step_neg = !(min1 > min0);
    end

    // Geometry registers, captured when a command is accepted.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_steep    <= n_steep;
            r_maj0     <= n_maj0;
            r_min0     <= n_min0;
            r_maj1     <= n_maj1;
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_step_neg <= n_step_neg;
        end
    end

    assign o_steep    = r_steep;
    assign o_maj0     = r_maj0;
    assign o_min0     = r_min0;
    assign o_maj1     = r_maj1;
    assign o_dx       = r_dx;
    assign o_dy       = r_dy;
    assign o_step_neg = r_step_neg;

endmodule

`default_nettype wire

### hw/rtl/lrb_step.sv
// Stepping unit: one shared error accumulator advances the line one pixel per cycle while the
// output is not stalled, and fills the pixel output register. Depends on lrb_pkg.
`default_nettype none

module lrb_step #(
    parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  lrb_pkg::t_step_ctl          i_ctl,
    input  wire                         i_steep,
    input  wire  [COORD_BITS-1:0]       i_maj0,
    input  wire  [COORD_BITS-1:0]       i_min0,
    input  wire  [COORD_BITS-1:0]       i_maj1,
    input  wire  [COORD_BITS-1:0]       i_dx,
    input  wire  [COORD_BITS-1:0]       i_dy,
    input  wire                         i_step_neg,
    input  wire  [lrb_pkg::COLOR_W-1:0] i_color,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output logic [COORD_BITS-1:0]       o_pixel_x,
    output logic [COORD_BITS-1:0]       o_pixel_y,
    output logic [lrb_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                        o_last_pixel,
    output logic                        o_done
);
    import lrb_pkg::*;

    // Error term width: holds twice the error with sign.
    localparam int EW = COORD_BITS + 3;

    logic                  r_steep;
    logic [COORD_BITS-1:0] r_major,  n_major;
    logic [COORD_BITS-1:0] r_minor,  n_minor;
    logic [COORD_BITS-1:0] r_maj1;
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic                  r_step_neg;
    logic signed [EW-1:0]  r_eps,    n_eps;

    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [COLOR_W-1:0]    r_out_color;
    logic                  r_out_last;

    logic                  emit;
    logic                  last;
    logic signed [EW-1:0]  dx_ext, dy_ext, eps_sum, eps_dbl;
    logic                  minor_move;

    // One pixel leaves the accumulator when the output register is free.
    assign emit = i_ctl.run && (!r_out_valid || i_out_ready);
    assign last = (r_major == r_maj1);

    // Error update: add the minor extent, step the minor axis when 2*eps >= dx.
    always_comb begin
        dx_ext     = $signed({{(EW - COORD_BITS){1'b0}}, r_dx});
        dy_ext     = $signed({{(EW - COORD_BITS){1'b0}}, r_dy});
        eps_sum    = r_eps + dy_ext;
        eps_dbl    = eps_sum <<< 1;
        minor_move = (eps_dbl >= dx_ext);
        n_major    = r_major + {{(COORD_BITS - 1){1'b0}}, 1'b1};
        n_minor    = r_minor;
        n_eps      = eps_sum;
        if (minor_move) begin
            n_minor = r_step_neg ? (r_minor - {{(COORD_BITS - 1){1'b0}}, 1'b1})
                                 : (r_minor + {{(COORD_BITS - 1){1'b0}}, 1'b1});
            n_eps   = eps_sum - dx_ext;
        end
    end

    // Walker registers: loaded from setup, then advanced per emitted pixel.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_steep    <= i_steep;
            r_major    <= i_maj0;
            r_minor    <= i_min0;
            r_maj1     <= i_maj1;
            r_dx       <= i_dx;
            r_dy       <= i_dy;
            r_step_neg <= i_step_neg;
            r_eps      <= '0;
        end else if (emit && !last) begin
            r_major <= n_major;
            r_minor <= n_minor;
            r_eps   <= n_eps;
        end
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload; axes are swapped back for steep lines.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= r_steep ? r_minor : r_major;
            r_out_y     <= r_steep ? r_major : r_minor;
            r_out_color <= i_color;
            r_out_last  <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;
    assign o_done        = emit && last;

    // The walker never passes the far endpoint while a line is running.
    a_major_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.run |-> (r_major <= r_maj1))
        else $error("major coordinate passed the line end");

    // The error term stays below half the major extent between pixels.
    a_eps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.run && (r_dx != '0)) |-> ((r_eps <<< 1) < dx_ext))
        else $error("error accumulator out of range");

    // A pixel taken into the output register is always presented next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("emitted pixel lost");

endmodule

`default_nettype wire

### hw/rtl/line_raster_bresenham.sv
// Bresenham line rasterizer: one command in, one pixel request out per pixel.
// The first pixel passes the setup registers, the load state and the pixel output
// register. Throughput: one pixel per cycle from the shared error accumulator while
// the output is not stalled; a line of major extent d gives d+1 pixels.
// Reset (synchronous, active low) returns the sequencer to idle, drops any pending
// pixel and clears the line color to zero.
`default_nettype none

module line_raster_bresenham #(
    parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    lrb_cmd_if.sink   i_cmd,
    lrb_cfg_if.sink   i_cfg,
    lrb_pix_if.source o_pix
);
    import lrb_pkg::*;

    t_state             r_state, n_state;
    t_step_ctl          step_ctl;
    logic               cmd_accept;
    logic [COLOR_W-1:0] r_line_color;
    logic [COLOR_W-1:0] r_color;
    logic               step_done;

    logic                  geo_steep;
    logic [COORD_BITS-1:0] geo_maj0, geo_min0, geo_maj1, geo_dx, geo_dy;
    logic                  geo_step_neg;

    // Color register; always ready for a write request.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_color <= '0;
        end else if (i_cfg.valid) begin
            r_line_color <= i_cfg.line_color;
        end
    end

    // Color seen by the command is held for all of its pixels.
    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_color <= r_line_color;
        end
    end

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and stepping controls.
    always_comb begin
        n_state       = r_state;
        step_ctl.load = 1'b0;
        step_ctl.run  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (cmd_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                step_ctl.load = 1'b1;
                n_state       = ST_RUN;
            end
            ST_RUN: begin
                step_ctl.run = 1'b1;
                if (step_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    lrb_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_clk      (i_clk),
        .i_load     (cmd_accept),
        .i_start_x  (i_cmd.start_x),
        .i_start_y  (i_cmd.start_y),
        .i_end_x    (i_cmd.end_x),
        .i_end_y    (i_cmd.end_y),
        .o_steep    (geo_steep),
        .o_maj0     (geo_maj0),
        .o_min0     (geo_min0),
        .o_maj1     (geo_maj1),
        .o_dx       (geo_dx),
        .o_dy       (geo_dy),
        .o_step_neg (geo_step_neg)
    );

    lrb_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (step_ctl),
        .i_steep       (geo_steep),
        .i_maj0        (geo_maj0),
        .i_min0        (geo_min0),
        .i_maj1        (geo_maj1),
        .i_dx          (geo_dx),
        .i_dy          (geo_dy),
        .i_step_neg    (geo_step_neg),
        .i_color       (r_color),
        .i_out_ready   (o_pix.ready),
        .o_out_valid   (o_pix.valid),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_pixel_color (o_pix.pixel_color),
        .o_last_pixel  (o_pix.last_pixel),
        .o_done        (step_done)
    );

    // An accepted command always goes through the load cycle.
    a_accept_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_accept |=> (r_state == ST_LOAD))
        else $error("accepted command skipped setup");

    // The last pixel of a line returns the sequencer to idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_done |=> (r_state == ST_IDLE))
        else $error("sequencer did not finish after the last pixel");

    // Completion is only reported while a line is running.
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_done |-> (r_state == ST_RUN))
        else $error("line completion outside of run state");

endmodule

`default_nettype wire
